// ===== hdl/pct_pkg.sv =====
// Package for the periodic callback timer table: sizes, codes, states.
// Used by pct_div, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
package pct_pkg;
    localparam int SLOTS      = 16;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ROW_W      = 32 * 5 + 16 * 2;
    localparam int DIV_STEPS  = 32;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_REM  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_ADD  = 2'd0,
        K_REM  = 2'd1,
        K_FIRE = 2'd2,
        K_DONE = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_SRD, S_SCHK, S_AWR, S_AOUT,
        S_REM, S_TRD, S_TCHK, S_TDONE
    } t_state;

    localparam logic [0:0] REG_PERIOD = 1'b0;
endpackage

// ===== hdl/pct_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module pct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write, and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hdl/pct_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient rounded up.
// Depends on pct_pkg.
`timescale 1ns / 1ps
module pct_div
    import pct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [9:0]  i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [31:0] r_q, n_q;
    logic [10:0] r_rem, n_rem;
    logic [9:0]  r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy;
    logic [10:0] w_sh;

    // shift one numerator bit in, subtract when it fits
    always_comb begin
        w_sh  = {r_rem[9:0], r_q[31]};
        n_q   = {r_q[30:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
        n_cnt = r_cnt + 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= (i_den == '0) ? 10'd1 : i_den;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= n_cnt;
                if (n_cnt == 6'(DIV_STEPS)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q + {31'd0, (r_rem != '0)};
endmodule

// ===== hdl/periodic_callback_timer_table.sv =====
// Top level of the periodic callback timer table: control sequencer,
// register port and the two slot memories. Depends on pct_pkg, pct_ram, pct_div.
//
//  channel   ports                              handshake
//  command   i_op .. i_cur_tid                  i_start while o_busy low
//  result    o_kind .. o_last                   o_valid, one cycle, no stall
//  config    psel penable pwrite paddr pwdata   APB, pready always high
//
// Add: the divider runs, then a slot search (read, check per slot) and a closing
// state, S_AWR or S_AOUT. Remove: the S_REM state.
// Tick: read and check per slot, then S_TDONE.
// After reset a clearing pass over all slots runs with o_busy high.
// One item at a time; results cannot be held off by the receiver.
`timescale 1ns / 1ps
module periodic_callback_timer_table
    import pct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_callback_addr,
    input  logic [31:0] i_delay_ms,
    input  logic [31:0] i_arg1,
    input  logic [31:0] i_arg2,
    input  logic [31:0] i_arg3,
    input  logic [31:0] i_arg4,
    input  logic [7:0]  i_slot_index,
    input  logic [15:0] i_cur_pid,
    input  logic [15:0] i_cur_tid,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [5:0]  o_out_slot,
    output logic        o_ok,
    output logic [31:0] o_out_callback,
    output logic [31:0] o_out_arg1,
    output logic [31:0] o_out_arg2,
    output logic [31:0] o_out_arg3,
    output logic [31:0] o_out_arg4,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_state r_state, n_state;
    logic [9:0]  r_period;
    logic [31:0] r_count;
    logic [SLOT_W:0] r_idx;
    logic [31:0] r_cb, r_a1, r_a2, r_a3, r_a4, r_ticks;
    logic [15:0] r_pid, r_tid;
    logic [7:0]  r_sidx;

    // hot memory: callback + deadline; cold memory: args, period, owner
    logic              w_hwe, w_cwe;
    logic [SLOT_W-1:0] w_addr;
    logic [63:0]       w_hwd, w_hrd;
    logic [ROW_W-1:0]  w_cwd, w_crd;
    logic              w_div_start, w_div_done;
    logic [31:0]       w_quot;

    pct_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_hot (
        .i_clk(i_clk), .i_we(w_hwe), .i_addr(w_addr), .i_wdata(w_hwd), .o_rdata(w_hrd));
    pct_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS)) u_cold (
        .i_clk(i_clk), .i_we(w_cwe), .i_addr(w_addr), .i_wdata(w_cwd), .o_rdata(w_crd));
    pct_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start), .i_num(i_delay_ms),
        .i_den(r_period), .o_done(w_div_done), .o_quot(w_quot));

    // unpack the read slot
    logic [31:0] w_scb, w_sdl, w_sper, w_sa1, w_sa2, w_sa3, w_sa4;
    logic [15:0] w_spid, w_stid;
    logic [31:0] w_cnt1;
    logic        w_last_slot, w_fire;
    assign {w_scb, w_sdl} = w_hrd;
    assign {w_sa1, w_sa2, w_sa3, w_sa4, w_sper, w_spid, w_stid} = w_crd;
    assign w_cnt1 = r_count;
    assign w_last_slot = (r_idx == (SLOT_W+1)'(SLOTS - 1));
    assign w_fire = (w_scb != '0) && (w_sdl < r_count) &&
                    (w_spid == r_pid) && (w_stid == r_tid);

    logic w_acc;
    assign w_acc = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign prdata = {22'd0, r_period};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (w_last_slot) n_state = S_IDLE;
            S_IDLE: begin
                if (w_acc) begin
                    case (t_op'(i_op))
                        OP_ADD:  n_state = S_DIV;
                        OP_REM:  n_state = S_REM;
                        OP_TICK: n_state = S_TRD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV:  if (w_div_done) n_state = S_SRD;
            S_SRD:  n_state = S_SCHK;
            S_SCHK: begin
                if (w_hrd == '0) n_state = S_AWR;
                else if (w_last_slot) n_state = S_AOUT;
                else n_state = S_SRD;
            end
            S_AWR:  n_state = S_IDLE;
            S_AOUT: n_state = S_IDLE;
            S_REM:  n_state = S_IDLE;
            S_TRD:  n_state = S_TCHK;
            S_TCHK: n_state = w_last_slot ? S_TDONE : S_TRD;
            S_TDONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        w_hwe = 1'b0;
        w_cwe = 1'b0;
        w_addr = r_idx[SLOT_W-1:0];
        w_hwd = '0;
        w_cwd = {r_a1, r_a2, r_a3, r_a4, r_ticks, r_pid, r_tid};
        w_div_start = w_acc && (t_op'(i_op) == OP_ADD);
        case (r_state)
            S_CLEAR: w_hwe = 1'b1;
            S_SCHK: if (w_hrd == '0) begin
                w_hwe = 1'b1;
                w_cwe = 1'b1;
                w_hwd = {r_cb, r_count + r_ticks};
            end
            S_REM: if (r_sidx < 8'(SLOTS)) begin
                w_hwe = 1'b1;
                w_addr = r_sidx[SLOT_W-1:0];
            end
            S_TCHK: if (w_fire) begin
                w_hwe = 1'b1;
                w_hwd = {w_scb, w_cnt1 + w_sper};
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_period <= 10'd10;
            r_count  <= '0;
            r_idx    <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            o_ok    <= 1'b0;
            o_last  <= 1'b0;
            o_out_slot <= '0;
            o_out_callback <= '0;
            o_out_arg1 <= '0;
            o_out_arg2 <= '0;
            o_out_arg3 <= '0;
            o_out_arg4 <= '0;
            if (psel && penable && pwrite && paddr == REG_PERIOD) begin
                r_period <= pwdata[9:0];
            end
            case (r_state)
                S_CLEAR: r_idx <= w_last_slot ? '0 : r_idx + 1'b1;
                S_IDLE: begin
                    r_idx <= '0;
                    if (w_acc) begin
                        r_cb <= i_callback_addr;
                        r_a1 <= i_arg1;
                        r_a2 <= i_arg2;
                        r_a3 <= i_arg3;
                        r_a4 <= i_arg4;
                        r_sidx <= i_slot_index;
                        r_pid <= i_cur_pid;
                        r_tid <= i_cur_tid;
                        if (t_op'(i_op) == OP_TICK) r_count <= r_count + 32'd1;
                    end
                end
                S_DIV: r_ticks <= w_quot;
                S_SCHK: if (w_hrd != '0 && !w_last_slot) r_idx <= r_idx + 1'b1;
                default: ;
            endcase
            // results
            case (r_state)
                S_SCHK: if (w_hrd == '0 || w_last_slot) begin
                    o_valid <= 1'b1;
                    o_kind <= K_ADD;
                    o_last <= 1'b1;
                    if (w_hrd == '0) begin
                        o_ok <= 1'b1;
                        o_out_slot <= 6'(r_idx);
                    end
                end
                S_REM: begin
                    o_valid <= 1'b1;
                    o_kind <= K_REM;
                    o_last <= 1'b1;
                end
                S_TCHK: begin
                    if (!w_last_slot) r_idx <= r_idx + 1'b1;
                    if (w_fire) begin
                        o_valid <= 1'b1;
                        o_kind <= K_FIRE;
                        o_out_slot <= 6'(r_idx);
                        o_out_callback <= w_scb;
                        o_out_arg1 <= w_sa1;
                        o_out_arg2 <= w_sa2;
                        o_out_arg3 <= w_sa3;
                        o_out_arg4 <= w_sa4;
                    end
                end
                S_TDONE: begin
                    o_valid <= 1'b1;
                    o_kind <= K_DONE;
                    o_last <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== dv/periodic_callback_timer_table_tb.sv =====
// Testbench for the periodic callback timer table: directed and random
// add/remove/tick words checked against a built-in timer table predictor.
// Depends on pct_pkg and periodic_callback_timer_table.
`timescale 1ns / 1ps
module periodic_callback_timer_table_tb
    import pct_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 100;

    typedef struct {
        t_op         op;
        logic [31:0] callback;
        logic [31:0] delay;
        logic [31:0] args [4];
        logic [7:0]  index;
        logic [15:0] pid;
        logic [15:0] tid;
    } t_cmd;

    typedef struct {
        t_kind       kind;
        logic [5:0]  slot;
        logic        ok;
        logic [31:0] callback;
        logic [31:0] args [4];
        logic        last;
    } t_res;

    // Timer table predictor with its queue of pending expected results
    class timer_scoreboard;
        logic [9:0]  period_ms;
        logic [31:0] ticks_now;
        logic [31:0] cb_tab [SLOTS];
        logic [31:0] due_tab [SLOTS];
        logic [31:0] per_tab [SLOTS];
        logic [31:0] arg_tab [SLOTS][4];
        logic [15:0] pid_tab [SLOTS];
        logic [15:0] tid_tab [SLOTS];
        t_res        pending [$];
        int          errors;

        function void clear_table();
            period_ms = 10'd10;
            ticks_now = '0;
            errors    = 0;
            for (int i = 0; i < SLOTS; i++) begin
                cb_tab[i]  = '0;
                due_tab[i] = '0;
            end
        endfunction

        function void set_period(logic [9:0] v);
            period_ms = v;
        endfunction

        function t_res blank(t_kind k, logic [5:0] slot, logic ok, logic last);
            t_res r;
            r.kind = k;
            r.slot = slot;
            r.ok = ok;
            r.callback = '0;
            for (int j = 0; j < 4; j++) r.args[j] = '0;
            r.last = last;
            return r;
        endfunction

        // Predict every result word caused by one accepted command
        function void note_cmd(t_cmd c);
            logic [31:0] dt;
            logic [31:0] nticks;
            t_res        r;
            bit          found;
            found = 0;
            case (c.op)
                OP_ADD: begin
                    dt = (period_ms == 0) ? 32'd1 : {22'd0, period_ms};
                    nticks = c.delay / dt + ((c.delay % dt) != 0 ? 32'd1 : 32'd0);
                    for (int i = 0; i < SLOTS && !found; i++) begin
                        if (cb_tab[i] == 0 && due_tab[i] == 0) begin
                            found = 1;
                            cb_tab[i]  = c.callback;
                            per_tab[i] = nticks;
                            due_tab[i] = ticks_now + nticks;
                            for (int j = 0; j < 4; j++) arg_tab[i][j] = c.args[j];
                            pid_tab[i] = c.pid;
                            tid_tab[i] = c.tid;
                            pending.push_back(blank(K_ADD, 6'(i), 1'b1, 1'b1));
                        end
                    end
                    if (!found) pending.push_back(blank(K_ADD, 6'd0, 1'b0, 1'b1));
                end
                OP_REM: begin
                    if (c.index < SLOTS) begin
                        cb_tab[c.index]  = '0;
                        due_tab[c.index] = '0;
                    end
                    pending.push_back(blank(K_REM, 6'd0, 1'b0, 1'b1));
                end
                OP_TICK: begin
                    ticks_now = ticks_now + 1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (cb_tab[i] != 0 && due_tab[i] < ticks_now &&
                            pid_tab[i] == c.pid && tid_tab[i] == c.tid) begin
                            due_tab[i] = ticks_now + per_tab[i];
                            r = blank(K_FIRE, 6'(i), 1'b0, 1'b0);
                            r.callback = cb_tab[i];
                            for (int j = 0; j < 4; j++) r.args[j] = arg_tab[i][j];
                            pending.push_back(r);
                        end
                    end
                    pending.push_back(blank(K_DONE, 6'd0, 1'b0, 1'b1));
                end
                default: ;
            endcase
        endfunction

        // Compare one result word against the oldest expectation
        function void check_result(t_res a);
            t_res e;
            bit   bad;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: kind %0d slot %0d", a.kind, a.slot);
                return;
            end
            e = pending.pop_front();
            bad = (a.kind != e.kind) || (a.slot != e.slot) || (a.ok != e.ok) ||
                  (a.callback != e.callback) || (a.last != e.last);
            for (int j = 0; j < 4; j++) bad = bad || (a.args[j] != e.args[j]);
            if (bad) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp kind %0d slot %0d ok %0d cb %h a %h %h %h %h last %0d",
                             e.kind, e.slot, e.ok, e.callback, e.args[0], e.args[1],
                             e.args[2], e.args[3], e.last,
                             "\n         got kind %0d slot %0d ok %0d cb %h a %h %h %h %h last %0d",
                             a.kind, a.slot, a.ok, a.callback, a.args[0], a.args[1],
                             a.args[2], a.args[3], a.last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_op;
    logic [31:0] i_callback_addr, i_delay_ms, i_arg1, i_arg2, i_arg3, i_arg4;
    logic [7:0]  i_slot_index;
    logic [15:0] i_cur_pid, i_cur_tid;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [5:0]  o_out_slot;
    logic        o_ok;
    logic [31:0] o_out_callback, o_out_arg1, o_out_arg2, o_out_arg3, o_out_arg4;
    logic        o_last;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    timer_scoreboard sb;
    int          idle_cycles;
    logic [15:0] owner_pid [3] = '{16'h1234, 16'hFFFF, 16'h0000};
    logic [15:0] owner_tid [3] = '{16'h00A5, 16'hFFFF, 16'h0000};

    periodic_callback_timer_table u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check every result word at the edge that ends its cycle
    always @(posedge i_clk) begin
        t_res a;
        if (i_rst_n && o_valid) begin
            a.kind = t_kind'(o_kind);
            a.slot = o_out_slot;
            a.ok = o_ok;
            a.callback = o_out_callback;
            a.args[0] = o_out_arg1;
            a.args[1] = o_out_arg2;
            a.args[2] = o_out_arg3;
            a.args[3] = o_out_arg4;
            a.last = o_last;
            sb.check_result(a);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (i_start && !o_busy) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_period(logic [9:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_PERIOD;
        pwdata  <= {22'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_period(v);
    endtask

    // Drive one command word after a random gap and wait until accepted
    task automatic send_cmd(t_cmd c);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_op            <= c.op;
        i_callback_addr <= c.callback;
        i_delay_ms      <= c.delay;
        i_arg1          <= c.args[0];
        i_arg2          <= c.args[1];
        i_arg3          <= c.args[2];
        i_arg4          <= c.args[3];
        i_slot_index    <= c.index;
        i_cur_pid       <= c.pid;
        i_cur_tid       <= c.tid;
        do @(posedge i_clk); while (o_busy);
        sb.note_cmd(c);
    endtask

    function automatic t_cmd make_cmd(t_op op, logic [31:0] cb, logic [31:0] delay,
                                      logic [31:0] fill, logic [7:0] index,
                                      logic [15:0] pid, logic [15:0] tid);
        t_cmd c;
        c.op = op;
        c.callback = cb;
        c.delay = delay;
        for (int j = 0; j < 4; j++) c.args[j] = fill ^ j;
        c.index = index;
        c.pid = pid;
        c.tid = tid;
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   pick;
        int   who;
        pick = $urandom_range(0, 99);
        who  = $urandom_range(0, 2);
        c = make_cmd(OP_ADD, $urandom, $urandom_range(0, 40), $urandom,
                     8'($urandom_range(0, SLOTS - 1)), owner_pid[who], owner_tid[who]);
        for (int j = 0; j < 4; j++) c.args[j] = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            c.pid = 16'($urandom);
            c.tid = 16'($urandom);
        end
        if (pick < 40) begin
            if ($urandom_range(0, 9) == 0) c.delay = $urandom;
            if ($urandom_range(0, 19) == 0) c.callback = '0;
        end else if (pick < 60) begin
            c.op = OP_REM;
            if ($urandom_range(0, 4) == 0) c.index = 8'($urandom);
        end else if (pick < 95) begin
            c.op = OP_TICK;
        end else begin
            c.op = OP_NONE;
        end
        return c;
    endfunction

    // Let any silent command finish before touching the register
    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    initial begin
        logic [9:0] periods [6];
        t_cmd c;
        int   sent;
        periods = '{10'd10, 10'd1, 10'd1000, 10'd0, 10'd7, 10'd3};
        sb = new();
        sb.clear_table();
        idle_cycles = 0;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_op <= OP_NONE;
        i_callback_addr <= '0;
        i_delay_ms <= '0;
        i_arg1 <= '0;
        i_arg2 <= '0;
        i_arg3 <= '0;
        i_arg4 <= '0;
        i_slot_index <= '0;
        i_cur_pid <= '0;
        i_cur_tid <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);

        // Directed: free-looking add, extremes, full table, ticks for one owner, removes
        write_period(10'd10);
        send_cmd(make_cmd(OP_ADD, 32'h0, 32'h0, 32'h0, 8'h0, 16'h0, 16'h0));
        send_cmd(make_cmd(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                          16'hFFFF, 16'hFFFF));
        for (int i = 1; i <= SLOTS; i++)
            send_cmd(make_cmd(OP_ADD, 32'h1000 + i, 32'd10, 32'hA5A5_0000 + i, 8'h0,
                              owner_pid[0], owner_tid[0]));
        send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, owner_pid[0], owner_tid[0]));
        send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, owner_pid[0], owner_tid[0]));
        send_cmd(make_cmd(OP_REM, 0, 0, 0, 8'hFF, 0, 0));
        send_cmd(make_cmd(OP_REM, 0, 0, 0, 8'd5, 0, 0));
        send_cmd(make_cmd(OP_NONE, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
        drain();

        // Random phases across several tick periods
        foreach (periods[p]) begin
            write_period(periods[p]);
            sent = 0;
            while (sent < 32) begin
                c = random_cmd();
                send_cmd(c);
                if (c.op != OP_NONE) sent++;
            end
            drain();
        end

        sb.errors += sb.pending.size();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
